/* hw/rtl/tli_pkg.sv */
package tli_pkg;

   localparam int MaxLines  = 4096;
   localparam int TextBytes = 65536;
   localparam int LineW     = $clog2(MaxLines);
   localparam int CountW    = $clog2(MaxLines + 1);
   localparam int OffW      = $clog2(TextBytes + 1);
   localparam int QueueDepth = 2;

   localparam logic [7:0] CharCr = 8'h0d;
   localparam logic [7:0] CharLf = 8'h0a;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_LOAD   = 3'd1,
      OP_POS    = 3'd2,
      OP_OFFSET = 3'd3,
      OP_BOUNDS = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TEXT_FULL = 2'd1,
      ST_LINE_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [7:0]        data_byte;
      logic [OffW-1:0]   query_offset;
      logic [LineW-1:0]  query_line;
      logic [OffW-1:0]   query_column;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [LineW-1:0]  line_number;
      logic [OffW-1:0]   column_number;
      logic [OffW-1:0]   result_offset;
      logic [OffW-1:0]   line_end;
      logic              line_valid;
      logic [CountW-1:0] line_count;
   } rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SEARCH_RD,
      BK_SEARCH_CMP,
      BK_POS_RD,
      BK_POS_DONE,
      BK_A_RD,
      BK_B_RD,
      BK_B_WAIT,
      BK_DONE
   } back_state_type;

endpackage

/* hw/rtl/text_line_index_core.sv */
// text line index core
// one command channel (req_*, start/busy) and one result channel (rsp_*).
// a command is taken when start is high and busy is low; each command
// gives exactly one result, shown for one cycle with rsp_strobe high.
// byte loads, clears and unused ops are answered straight from the queue head
// and stream at one per cycle while no query holds the back end;
// op 3 and op 4 read the start of the query line, then the start of the next one;
// op 2 runs a binary search over the single read port of the start table,
// and an offset at or past the end of the text skips the search.
// a query holds the back end until its result is formed; a two-entry
// queue sits between command decode and execution, so busy rises only
// when that queue is full.
// reset (synchronous) empties the queue and sets one line and no text;
// the receiver cannot stall, so results never wait.
module text_line_index_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tli_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output tli_pkg::rsp_type rsp_payload
);
   import tli_pkg::*;

   logic    q_push, q_full, q_pop, q_valid;
   req_type q_in, q_out;

   tli_front u_front (
      .start(start), .busy(busy),
      .req(req_payload), .q_full(q_full), .q_push(q_push), .q_data(q_in));

   tli_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .pop(q_pop), .not_empty(q_valid), .pop_data(q_out));

   tli_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_out),
      .q_pop(q_pop), .rsp_strobe(rsp_strobe), .rsp(rsp_payload));

endmodule

/* hw/rtl/tli_ram.sv */
module tli_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/tli_front.sv */
module tli_front (
   input  logic            start,
   output logic            busy,
   input  tli_pkg::req_type req,
   input  logic            q_full,
   output logic            q_push,
   output tli_pkg::req_type q_data
);

   // front side only stalls on a full queue
   assign busy   = q_full;
   assign q_push = start && !q_full;
   assign q_data = req;

endmodule

/* hw/rtl/tli_queue.sv */
module tli_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tli_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output tli_pkg::req_type pop_data
);
   import tli_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   req_type            slot_ff [QueueDepth];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]      count_ff;

   assign full      = (count_ff == (PtrW + 1)'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
      end
   end

endmodule

/* hw/rtl/tli_back.sv */
module tli_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  tli_pkg::req_type q_data,
   output logic             q_pop,
   output logic             rsp_strobe,
   output tli_pkg::rsp_type rsp
);
   import tli_pkg::*;

   back_state_type state_ff, state_in;

   logic [CountW-1:0] lines_ff;
   logic [OffW-1:0]   text_len_ff;
   logic              pend_cr_ff;
   req_type           cur_ff;
   logic [LineW-1:0]  lo_ff, hi_ff, mid_ff;
   logic [OffW-1:0]   a_ff;

   // memory ports
   logic              st_we, tl_we;
   logic [LineW-1:0]  st_wa, tl_wa, rd_addr;
   logic [OffW-1:0]   st_wd, st_rd;
   logic [1:0]        tl_wd, tl_rd;

   tli_ram #(.Width(OffW), .Depth(MaxLines)) u_starts (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(rd_addr), .rd_data(st_rd));
   tli_ram #(.Width(2), .Depth(MaxLines)) u_terms (
      .clock(clock), .wr_en(tl_we), .wr_addr(tl_wa), .wr_data(tl_wd),
      .rd_addr(rd_addr), .rd_data(tl_rd));

   // entry zero reads as zero
   logic             rd_zero_ff;
   logic [OffW-1:0]  st_val;
   assign st_val = rd_zero_ff ? '0 : st_rd;

   // byte load decode, combinational, straight from the queue head
   logic             is_load, is_clear, take_fast;
   logic             can_push, is_cr, is_lf, pair_lf;
   logic [LineW-1:0] last_idx;
   logic [OffW-1:0]  next_off;
   assign is_load  = q_valid && (q_data.op == OP_LOAD);
   assign is_clear = q_valid && (q_data.op == OP_CLEAR);
   assign can_push = (lines_ff < CountW'(MaxLines));
   assign is_cr    = (q_data.data_byte == CharCr);
   assign is_lf    = (q_data.data_byte == CharLf);
   assign pair_lf  = is_lf && pend_cr_ff && (lines_ff >= CountW'(2));
   assign last_idx = LineW'(lines_ff - 1'b1);
   assign next_off = text_len_ff + 1'b1;
   assign take_fast = (state_ff == BK_IDLE) && (is_load || is_clear
                      || (q_valid && q_data.op != OP_POS && q_data.op != OP_OFFSET
                          && q_data.op != OP_BOUNDS));

   logic text_full;
   assign text_full = (text_len_ff >= OffW'(TextBytes));

   // offset at or past the end answers the last line
   logic pos_past_end;
   assign pos_past_end = (q_data.query_offset >= text_len_ff);

   // table writes
   always_comb begin
      st_we = 1'b0; tl_we = 1'b0;
      st_wa = last_idx; tl_wa = last_idx;
      st_wd = next_off; tl_wd = 2'd1;
      if (state_ff == BK_IDLE && is_load && !text_full) begin
         if (pair_lf) begin
            st_we = 1'b1; tl_we = 1'b1;
            st_wa = last_idx;
            tl_wa = LineW'(lines_ff - 2'd2);
            tl_wd = 2'd2;
         end else if ((is_cr || is_lf) && can_push) begin
            st_we = 1'b1; tl_we = 1'b1;
            st_wa = LineW'(lines_ff);
            tl_wa = last_idx;
         end
      end
   end

   // read address
   logic [LineW:0] span;
   logic [LineW-1:0] mid_c;
   assign span  = {1'b0, hi_ff} - {1'b0, lo_ff} + 1'b1;
   assign mid_c = lo_ff + LineW'(span >> 1);
   always_comb begin
      unique case (state_ff)
         BK_SEARCH_RD: rd_addr = mid_c;
         BK_POS_RD:    rd_addr = lo_ff;
         BK_A_RD:      rd_addr = cur_ff.query_line;
         BK_B_RD:      rd_addr = cur_ff.query_line + 1'b1;
         default:      rd_addr = '0;
      endcase
   end

   logic qline_last, qline_missing;
   assign qline_last    = ({1'b0, cur_ff.query_line} + 1'b1) >= (LineW + 1)'(lines_ff);
   assign qline_missing = CountW'(cur_ff.query_line) >= lines_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && !take_fast) begin
               if (q_data.op == OP_POS) begin
                  state_in = pos_past_end ? BK_POS_RD : BK_SEARCH_RD;
               end else begin
                  state_in = BK_A_RD;
               end
            end
         end
         BK_SEARCH_RD:  state_in = BK_SEARCH_CMP;
         BK_SEARCH_CMP: state_in = BK_SEARCH_RD;
         BK_POS_RD:     state_in = BK_POS_DONE;
         BK_POS_DONE:   state_in = BK_DONE;
         BK_A_RD:       state_in = BK_B_RD;
         BK_B_RD:       state_in = BK_B_WAIT;
         BK_B_WAIT:     state_in = BK_DONE;
         BK_DONE:       state_in = BK_IDLE;
         default:       state_in = BK_IDLE;
      endcase
      if (state_ff == BK_SEARCH_RD && lo_ff == hi_ff) state_in = BK_POS_RD;
   end

   assign q_pop = (state_ff == BK_IDLE && q_valid);

   // datapath and architectural state
   always_ff @(posedge clock) begin
      rd_zero_ff <= (rd_addr == '0);
      if (state_ff == BK_IDLE && q_valid) begin
         cur_ff <= q_data;
         lo_ff  <= pos_past_end ? last_idx : '0;
         hi_ff  <= last_idx;
      end
      if (state_ff == BK_SEARCH_RD) mid_ff <= mid_c;
      if (state_ff == BK_SEARCH_CMP) begin
         if (st_val <= cur_ff.query_offset) lo_ff <= mid_ff;
         else hi_ff <= mid_ff - 1'b1;
      end
      if (state_ff == BK_B_RD) a_ff <= st_val;
   end

   // terminator of query line is read with line start; keep it
   logic [1:0] t_a_ff;
   always_ff @(posedge clock) begin
      if (state_ff == BK_B_RD) t_a_ff <= tl_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         lines_ff    <= CountW'(1);
         text_len_ff <= '0;
         pend_cr_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_IDLE && is_clear) begin
            lines_ff    <= CountW'(1);
            text_len_ff <= '0;
            pend_cr_ff  <= 1'b0;
         end else if (state_ff == BK_IDLE && is_load && !text_full) begin
            text_len_ff <= next_off;
            pend_cr_ff  <= is_cr && can_push;
            if (!pair_lf && (is_cr || is_lf) && can_push) lines_ff <= lines_ff + 1'b1;
         end
      end
   end

   // result formation
   rsp_type  rsp_in;
   logic     strobe_in;
   logic [OffW-1:0] e_trim, sum;
   assign sum = a_ff + cur_ff.query_column;
   assign e_trim = ((st_val - a_ff) >= OffW'(t_a_ff)) ? st_val - OffW'(t_a_ff) : a_ff;
   always_comb begin
      rsp_in = '0;
      strobe_in = 1'b0;
      rsp_in.line_count = lines_ff;
      if (take_fast) begin
         strobe_in = 1'b1;
         if (is_clear) rsp_in.line_count = CountW'(1);
         else if (is_load) begin
            if (text_full) rsp_in.status = ST_TEXT_FULL;
            else if (!pair_lf && (is_cr || is_lf) && !can_push) rsp_in.status = ST_LINE_FULL;
            if (!text_full && !pair_lf && (is_cr || is_lf) && can_push)
               rsp_in.line_count = lines_ff + 1'b1;
         end
      end else if (state_ff == BK_POS_DONE) begin
         strobe_in = 1'b1;
         rsp_in.line_number = lo_ff;
         if (cur_ff.query_offset >= text_len_ff) rsp_in.column_number = text_len_ff - st_val;
         else rsp_in.column_number = cur_ff.query_offset - st_val;
      end else if (state_ff == BK_B_WAIT) begin
         strobe_in = 1'b1;
         if (cur_ff.op == OP_OFFSET) begin
            if (qline_last) rsp_in.result_offset = text_len_ff;
            else rsp_in.result_offset = (sum > st_val || sum < a_ff) ? st_val : sum;
         end else if (!qline_missing) begin
            rsp_in.line_valid    = 1'b1;
            rsp_in.result_offset = a_ff;
            rsp_in.line_end      = qline_last ? text_len_ff : e_trim;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= strobe_in;
      end
      rsp <= rsp_in;
   end

endmodule

/* verif/text_line_index_core_tb.sv */
`timescale 1ns / 1ps

module text_line_index_core_tb;
   import tli_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   text_line_index_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   // mirror of the line table
   logic [16:0] mirror_starts [MaxLines];
   logic [1:0]  mirror_terms [MaxLines];
   int unsigned mirror_lines;
   int unsigned mirror_length;
   bit          mirror_cr_pending;

   rsp_type answers_due[$];
   int unsigned failures;
   int unsigned idle_cycles;
   int unsigned sender_idle_pct;

   // directed table: request plus hand-typed answer where obvious
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } step_row_type;

   always #10 clock = ~clock;

   function automatic rsp_type blank_rsp();
      rsp_type r;
      r = '0;
      return r;
   endfunction

   function automatic req_type make_req(op_type op, logic [7:0] b, logic [16:0] qoff,
                                        logic [11:0] qline, logic [16:0] qcol);
      req_type q;
      q.op = op;
      q.data_byte = b;
      q.query_offset = qoff;
      q.query_line = qline;
      q.query_column = qcol;
      return q;
   endfunction

   function automatic void mirror_clear();
      mirror_starts[0] = '0;
      mirror_terms[0] = '0;
      mirror_lines = 1;
      mirror_length = 0;
      mirror_cr_pending = 0;
   endfunction

   // add a break; 0 when the table has no room
   function automatic bit add_break(int unsigned next_start);
      if (mirror_lines >= MaxLines) return 0;
      mirror_terms[mirror_lines - 1] = 2'd1;
      mirror_starts[mirror_lines] = next_start[16:0];
      mirror_terms[mirror_lines] = '0;
      mirror_lines++;
      return 1;
   endfunction

   function automatic status_type append_byte(logic [7:0] b);
      int unsigned idx;
      bit was_cr;
      was_cr = mirror_cr_pending;
      if (mirror_length >= TextBytes) return ST_TEXT_FULL;
      idx = mirror_length;
      mirror_length++;
      mirror_cr_pending = 0;
      if (b == CharCr) begin
         if (!add_break(idx + 1)) return ST_LINE_FULL;
         mirror_cr_pending = 1;
      end else if (b == CharLf) begin
         if (was_cr && mirror_lines >= 2) begin
            mirror_starts[mirror_lines - 1] = 17'(idx + 1);
            mirror_terms[mirror_lines - 2] = 2'd2;
         end else if (!add_break(idx + 1)) begin
            return ST_LINE_FULL;
         end
      end
      return ST_OK;
   endfunction

   // compute the answer to one command and update the mirror
   function automatic rsp_type index_answer(req_type q);
      rsp_type r;
      int unsigned lo, hi, mid, s, e, o, t;
      r = blank_rsp();
      case (q.op)
         OP_CLEAR: mirror_clear();
         OP_LOAD: r.status = append_byte(q.data_byte);
         OP_POS: begin
            if (q.query_offset >= mirror_length) begin
               lo = mirror_lines - 1;
               r.column_number = 17'(mirror_length - mirror_starts[lo]);
            end else begin
               lo = 0;
               hi = mirror_lines - 1;
               while (lo < hi) begin
                  mid = lo + (hi - lo + 1) / 2;
                  if (mirror_starts[mid] <= q.query_offset) lo = mid;
                  else hi = mid - 1;
               end
               r.column_number = 17'(q.query_offset - mirror_starts[lo]);
            end
            r.line_number = 12'(lo);
         end
         OP_OFFSET: begin
            if (q.query_line + 1 >= mirror_lines) begin
               r.result_offset = 17'(mirror_length);
            end else begin
               s = mirror_starts[q.query_line];
               e = mirror_starts[q.query_line + 1];
               o = s + q.query_column;
               r.result_offset = 17'((o > e) ? e : o);
            end
         end
         OP_BOUNDS: begin
            if (q.query_line < mirror_lines) begin
               s = mirror_starts[q.query_line];
               if (q.query_line + 1 == mirror_lines) begin
                  e = mirror_length;
               end else begin
                  t = mirror_terms[q.query_line];
                  e = mirror_starts[q.query_line + 1];
                  e = (e - s >= t) ? e - t : s;
               end
               r.result_offset = 17'(s);
               r.line_end = 17'(e);
               r.line_valid = 1'b1;
            end
         end
         default: ;
      endcase
      r.line_count = 13'(mirror_lines);
      return r;
   endfunction

   // one command transfer; expected answer queued at acceptance
   task automatic issue_cmd(req_type q, bit typed, rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = index_answer(q);
      if (typed && typed_rsp != predicted) begin
         $error("table row disagrees with prediction: exp %h pred %h", typed_rsp, predicted);
         failures++;
      end
      answers_due.insert(answers_due.size(), typed ? typed_rsp : predicted);
   endtask

   // result check
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               $error("unexpected result %h", rsp_payload);
               failures++;
            end else begin
               exp_rsp = answers_due.pop_front();
               if (rsp_payload.status != exp_rsp.status) begin
                  $error("status exp %0d got %0d", exp_rsp.status, rsp_payload.status);
                  failures++;
               end
               if (rsp_payload.line_number != exp_rsp.line_number) begin
                  $error("line_number exp %0d got %0d", exp_rsp.line_number,
                         rsp_payload.line_number);
                  failures++;
               end
               if (rsp_payload.column_number != exp_rsp.column_number) begin
                  $error("column_number exp %0d got %0d", exp_rsp.column_number,
                         rsp_payload.column_number);
                  failures++;
               end
               if (rsp_payload.result_offset != exp_rsp.result_offset) begin
                  $error("result_offset exp %0d got %0d", exp_rsp.result_offset,
                         rsp_payload.result_offset);
                  failures++;
               end
               if (rsp_payload.line_end != exp_rsp.line_end) begin
                  $error("line_end exp %0d got %0d", exp_rsp.line_end, rsp_payload.line_end);
                  failures++;
               end
               if (rsp_payload.line_valid != exp_rsp.line_valid) begin
                  $error("line_valid exp %0d got %0d", exp_rsp.line_valid,
                         rsp_payload.line_valid);
                  failures++;
               end
               if (rsp_payload.line_count != exp_rsp.line_count) begin
                  $error("line_count exp %0d got %0d", exp_rsp.line_count,
                         rsp_payload.line_count);
                  failures++;
               end
            end
         end
         // watchdog on cycles with no transfer in either direction
         if (rsp_strobe || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // random bytes biased towards line breaks
   function automatic logic [7:0] text_byte();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) return CharCr;
      if (pick < 30) return CharLf;
      return 8'($urandom_range(255));
   endfunction

   task automatic random_query();
      int unsigned pick;
      logic [16:0] qoff, qcol;
      logic [11:0] qline;
      pick = $urandom_range(9);
      qoff = (pick < 6) ? 17'($urandom_range(mirror_length + 2)) : 17'($urandom);
      qline = (pick < 6) ? 12'($urandom_range(mirror_lines)) : 12'($urandom);
      qcol = (pick < 5) ? 17'($urandom_range(40)) : 17'($urandom);
      case ($urandom_range(3))
         0: issue_cmd(make_req(OP_POS, 8'($urandom), qoff, qline, qcol), 0, blank_rsp());
         1: issue_cmd(make_req(OP_OFFSET, 8'($urandom), qoff, qline, qcol), 0, blank_rsp());
         2: issue_cmd(make_req(OP_BOUNDS, 8'($urandom), qoff, qline, qcol), 0, blank_rsp());
         default: issue_cmd(make_req(op_type'(3'($urandom_range(5, 7))), 8'($urandom), qoff,
                                     qline, qcol), 0, blank_rsp());
      endcase
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      step_row_type steps[$];
      step_row_type row;
      rsp_type r;
      int unsigned phase, n;
      logic [7:0] sample_text[$];
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      failures = 0;
      sender_idle_pct = 0;
      mirror_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows: queries on empty text, each break kind, unused ops
      r = blank_rsp(); r.line_count = 13'd1; r.line_valid = 1'b1;
      row.req = make_req(OP_BOUNDS, 8'h00, '0, 12'd0, '0); row.typed = 1; row.rsp = r;
      steps.insert(steps.size(), row);
      r = blank_rsp(); r.line_count = 13'd1;
      row.req = make_req(OP_BOUNDS, 8'hff, 17'h1ffff, 12'hfff, 17'h1ffff); row.rsp = r;
      steps.insert(steps.size(), row);
      row.req = make_req(OP_POS, 8'h00, 17'h1ffff, 12'd0, '0); steps.insert(steps.size(), row);
      row.req = make_req(op_type'(3'd7), 8'hff, 17'h1ffff, 12'hfff, 17'h1ffff);
      steps.insert(steps.size(), row);
      row.req = make_req(op_type'(3'd5), 8'h00, '0, '0, '0); steps.insert(steps.size(), row);
      row.typed = 0;
      sample_text = '{8'h41, CharCr, CharLf, 8'h42, CharCr, 8'h43, CharLf,
                      CharLf, 8'hff, 8'h00, CharCr};
      foreach (sample_text[i]) begin
         row.req = make_req(OP_LOAD, sample_text[i], '0, '0, '0);
         steps.insert(steps.size(), row);
      end
      row.req = make_req(OP_POS, 8'h00, 17'd4, '0, '0); steps.insert(steps.size(), row);
      row.req = make_req(OP_OFFSET, 8'h00, '0, 12'd1, 17'h1ffff);
      steps.insert(steps.size(), row);
      row.req = make_req(OP_OFFSET, 8'h00, '0, 12'd0, 17'd1); steps.insert(steps.size(), row);
      row.req = make_req(OP_BOUNDS, 8'h00, '0, 12'd0, '0); steps.insert(steps.size(), row);
      row.req = make_req(OP_BOUNDS, 8'h00, '0, 12'd5, '0); steps.insert(steps.size(), row);
      r = blank_rsp(); r.line_count = 13'd1;
      row.req = make_req(OP_CLEAR, 8'h00, '0, '0, '0); row.typed = 1; row.rsp = r;
      steps.insert(steps.size(), row);
      foreach (steps[i]) issue_cmd(steps[i].req, steps[i].typed, steps[i].rsp);

      // random phases with varying sender idling
      for (phase = 0; phase < 4; phase++) begin
         sender_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 20 : 0;
         issue_cmd(make_req(OP_CLEAR, '0, '0, '0, '0), 0, blank_rsp());
         for (n = 0; n < 300; n++) begin
            if ($urandom_range(99) < 75)
               issue_cmd(make_req(OP_LOAD, text_byte(), '0, '0, '0), 0, blank_rsp());
            else
               random_query();
         end
      end

      // closing queries on the text left by the last phase
      sender_idle_pct = 0;
      for (n = 0; n < 30; n++) random_query();
      issue_cmd(make_req(OP_LOAD, CharLf, '0, '0, '0), 0, blank_rsp());
      issue_cmd(make_req(OP_POS, '0, 17'h10000, '0, '0), 0, blank_rsp());
      issue_cmd(make_req(OP_BOUNDS, '0, '0, 12'hfff, '0), 0, blank_rsp());

      wait_drained();
      if (failures == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
